/* sv/esz_pkg.sv */
// Package for the oriented ellipsoid zone search block.
// Holds codes, field widths, state encoding and the control structs.
// Used by the arithmetic unit and the top module of the block.
package esz_pkg;

  // Field widths.
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned SEL_W     = 5;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned SYS_W     = 32;
  localparam int unsigned POS_W     = 25;
  localparam int unsigned ROT_W     = 16;
  localparam int unsigned OFF_W     = 32;
  localparam int unsigned AXIS_W    = 25;
  localparam int unsigned DMG_W     = 16;
  localparam int unsigned ZONES_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Arithmetic widths.
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned PROD_W = 43;
  localparam int unsigned NUM_W  = 50;
  localparam int unsigned DVS_W  = 41;
  localparam int unsigned QUO_W  = 17;
  localparam int unsigned SUM_W  = 34;
  localparam int unsigned STEP_W = 5;

  // Defaults and constants.
  localparam int unsigned MAX_ZONES_DEF = 64;
  localparam logic [DMG_W-1:0] THR_RESET = 16'd250;
  localparam logic [SUM_W-1:0] INSIDE_LIMIT = 34'h1_0000_0000;
  localparam logic [STEP_W-1:0] DIV_LAST = 5'd16;

  // Word select codes.
  localparam logic [SEL_W-1:0] SEL_ROT_LAST   = 5'd8;
  localparam logic [SEL_W-1:0] SEL_OFF_FIRST  = 5'd9;
  localparam logic [SEL_W-1:0] SEL_OFF_LAST   = 5'd11;
  localparam logic [SEL_W-1:0] SEL_AXIS_FIRST = 5'd12;
  localparam logic [SEL_W-1:0] SEL_AXIS_LAST  = 5'd14;
  localparam logic [SEL_W-1:0] SEL_DAMAGE     = 5'd15;
  localparam logic [SEL_W-1:0] SEL_SYSTEM     = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE  = 2'd0,
    MODE_ANY    = 2'd1,
    MODE_LETHAL = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZONES = 2'd0,
    CFG_THR   = 2'd1
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR_RD,
    S_HDR_CHK,
    S_ROT_RD,
    S_ROT_MAC,
    S_CHECK,
    S_DIV,
    S_SQ,
    S_DECIDE,
    S_NEXT,
    S_OUT
  } state_e;

  // Commands from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic mac_first;
    logic mac;
    logic div_init;
    logic div_step;
    logic square;
    logic sum_clr;
  } cmd_t;

  // Status from the arithmetic unit.
  typedef struct packed {
    logic axis_fail;
    logic in_zone;
  } stat_t;

endpackage

/* sv/esz_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module esz_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/esz_arith.sv */
// Shared arithmetic unit: one signed multiplier for the rotation products
// and the squares, a restoring divider step and the distance accumulators.
// Depends on esz_pkg.
module esz_arith (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  esz_pkg::cmd_t                 cmd_i,
  input  logic signed [esz_pkg::POS_W-1:0] pos_i,
  input  logic signed [esz_pkg::ROT_W-1:0] rot_i,
  input  logic signed [esz_pkg::OFF_W-1:0] off_i,
  input  logic [esz_pkg::AXIS_W-1:0]    size_i,
  output esz_pkg::stat_t                stat_o
);
  import esz_pkg::*;

  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [AXIS_W-1:0]        size_q, size_d;
  logic [NUM_W-1:0]         num_q, num_d;
  logic [DVS_W-1:0]         dvs_q, dvs_d;
  logic [QUO_W-1:0]         quo_q, quo_d;
  logic [SUM_W-1:0]         sum_q, sum_d;
  logic signed [POS_W-1:0]  mul_a;
  logic signed [17:0]       mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         mag;
  logic                     ge;

  // Operand select for the shared multiplier.
  always_comb begin
    if (cmd_i.square) begin
      mul_a = $signed({8'b0, quo_q});
      mul_b = $signed({1'b0, quo_q});
    end else begin
      mul_a = pos_i;
      mul_b = $signed({{2{rot_i[ROT_W-1]}}, rot_i});
    end
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Magnitude of the accumulated axis coordinate and the divider compare.
  assign mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign ge  = num_q >= {9'b0, dvs_q};

  always_comb begin
    acc_d  = acc_q;
    size_d = size_q;
    num_d  = num_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    sum_d  = sum_q;
    if (cmd_i.mac_first) begin
      acc_d  = $signed({{2{off_i[OFF_W-1]}}, off_i, 14'b0})
             + $signed({{5{prod[PROD_W-1]}}, prod});
      size_d = size_i;
    end
    if (cmd_i.mac) begin
      acc_d = acc_q + $signed({{5{prod[PROD_W-1]}}, prod});
    end
    if (cmd_i.div_init) begin
      num_d = {mag, 2'b0};
      dvs_d = {size_q, 16'b0};
      quo_d = '0;
    end
    if (cmd_i.div_step) begin
      num_d = ge ? (num_q - {9'b0, dvs_q}) : num_q;
      quo_d = {quo_q[QUO_W-2:0], ge};
      dvs_d = dvs_q >> 1;
    end
    if (cmd_i.square) begin
      sum_d = sum_q + SUM_W'(prod);
    end
    if (cmd_i.sum_clr) begin
      sum_d = '0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    size_q <= size_d;
    num_q  <= num_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
  end

  // The sum also gates the result, so it starts from a known value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign stat_o.axis_fail = (size_q == '0) || (mag > {9'b0, size_q, 14'b0});
  assign stat_o.in_zone   = sum_q <= INSIDE_LIMIT;

endmodule

/* sv/oriented_ellipsoid_zone_search.sv */
// Oriented ellipsoid zone search: zone table in RAMs, a slot sequencer and
// one shared multiply/divide unit. A query walks the slots in order; a slot
// that misses on system goes straight to the next, and a fully tested slot
// reads each rotation coefficient before its product is accumulated, then
// runs 17 divider steps per axis. Reset clears the sequencer, configuration,
// result and sum registers; the zone table is not cleared.
module oriented_ellipsoid_zone_search #(
  parameter int unsigned MAX_ZONES = esz_pkg::MAX_ZONES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [esz_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [esz_pkg::CFG_DAT_W-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [esz_pkg::MODE_W-1:0]           mode_i,
  input  logic [esz_pkg::SLOT_W-1:0]           zone_slot_i,
  input  logic [esz_pkg::SEL_W-1:0]            word_select_i,
  input  logic signed [esz_pkg::WORD_W-1:0]    word_value_i,
  input  logic [esz_pkg::SYS_W-1:0]            system_id_i,
  input  logic signed [esz_pkg::POS_W-1:0]     pos_x_i,
  input  logic signed [esz_pkg::POS_W-1:0]     pos_y_i,
  input  logic signed [esz_pkg::POS_W-1:0]     pos_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 found_o,
  output logic [esz_pkg::SLOT_W-1:0]           zone_index_o,
  output logic [esz_pkg::DMG_W-1:0]            zone_damage_o
);
  import esz_pkg::*;

  localparam int unsigned ROT_D  = MAX_ZONES * 9;
  localparam int unsigned AX_D   = MAX_ZONES * 3;
  localparam int unsigned ROT_AW = $clog2(ROT_D);
  localparam int unsigned AX_AW  = $clog2(AX_D);
  localparam int unsigned Z_AW   = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_ZONES + 1);

  state_e state_q, state_d;
  logic [ZONES_W-1:0] zones_q;
  logic [DMG_W-1:0]   thr_q;
  logic [CNT_W-1:0]   slot_q, slot_d, count_q, count_d;
  logic [1:0]         i_q, i_d, j_q, j_d;
  logic [STEP_W-1:0]  k_q, k_d;
  logic               lethal_q, lethal_d;
  logic [SYS_W-1:0]   sys_q;
  logic signed [POS_W-1:0] px_q, py_q, pz_q;
  logic               found_q, found_d;
  logic [SLOT_W-1:0]  idx_q, idx_d;
  logic [DMG_W-1:0]   dmg_q, dmg_d;
  logic [DMG_W-1:0]   cand_dmg_q, cand_dmg_d;

  logic in_acc, query_acc, wr_ok;
  logic we_rot, we_off, we_ax, we_dmg, we_sys;
  logic [ROT_AW-1:0] rot_wa, rot_ra;
  logic [AX_AW-1:0]  ax_wa, ax_ra;
  logic [Z_AW-1:0]   z_wa, z_ra;
  logic [AXIS_W-1:0] ax_wd;
  logic [DMG_W-1:0]  dmg_wd;
  logic signed [ROT_W-1:0] rot_rd;
  logic signed [OFF_W-1:0] off_rd;
  logic [AXIS_W-1:0] ax_rd;
  logic [DMG_W-1:0]  dmg_rd;
  logic [SYS_W-1:0]  sys_rd;
  logic signed [POS_W-1:0] pos_sel;
  cmd_t  cmd;
  stat_t stat;

  // Handshakes follow the sequencer state only.
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign query_acc   = in_acc && (mode_i == MODE_ANY || mode_i == MODE_LETHAL);

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zones_q <= '0;
      thr_q   <= THR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ZONES: zones_q <= cfg_data_i[ZONES_W-1:0];
        CFG_THR:   thr_q   <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Table write decode, with radius and damage saturation.
  assign wr_ok  = in_acc && (mode_i == MODE_WRITE) && (32'(zone_slot_i) < MAX_ZONES);
  assign we_rot = wr_ok && (word_select_i <= SEL_ROT_LAST);
  assign we_off = wr_ok && (word_select_i inside {[SEL_OFF_FIRST:SEL_OFF_LAST]});
  assign we_ax  = wr_ok && (word_select_i inside {[SEL_AXIS_FIRST:SEL_AXIS_LAST]});
  assign we_dmg = wr_ok && (word_select_i == SEL_DAMAGE);
  assign we_sys = wr_ok && (word_select_i == SEL_SYSTEM);

  assign rot_wa = ROT_AW'(32'(zone_slot_i) * 9 + 32'(word_select_i));
  assign ax_wa  = AX_AW'(32'(zone_slot_i) * 3
                + 32'(we_off ? word_select_i - SEL_OFF_FIRST
                             : word_select_i - SEL_AXIS_FIRST));
  assign z_wa   = Z_AW'(zone_slot_i);

  assign ax_wd  = word_value_i[WORD_W-1] ? '0 :
                  (word_value_i[WORD_W-2:AXIS_W] != '0) ? '1 : word_value_i[AXIS_W-1:0];
  assign dmg_wd = word_value_i[WORD_W-1] ? '0 :
                  (word_value_i[WORD_W-2:DMG_W] != '0) ? '1 : word_value_i[DMG_W-1:0];

  // Read addresses follow the sequencer counters.
  assign rot_ra = ROT_AW'(32'(slot_q) * 9 + 32'(i_q) * 3 + 32'(j_q));
  assign ax_ra  = AX_AW'(32'(slot_q) * 3 + 32'(j_q));
  assign z_ra   = Z_AW'(slot_q);

  esz_ram #(.WIDTH(ROT_W), .DEPTH(ROT_D)) u_rot_ram (
    .clk_i(clk_i), .we_i(we_rot), .waddr_i(rot_wa), .wdata_i(word_value_i[ROT_W-1:0]),
    .raddr_i(rot_ra), .rdata_o(rot_rd)
  );
  esz_ram #(.WIDTH(OFF_W), .DEPTH(AX_D)) u_off_ram (
    .clk_i(clk_i), .we_i(we_off), .waddr_i(ax_wa), .wdata_i(word_value_i),
    .raddr_i(ax_ra), .rdata_o(off_rd)
  );
  esz_ram #(.WIDTH(AXIS_W), .DEPTH(AX_D)) u_axis_ram (
    .clk_i(clk_i), .we_i(we_ax), .waddr_i(ax_wa), .wdata_i(ax_wd),
    .raddr_i(ax_ra), .rdata_o(ax_rd)
  );
  esz_ram #(.WIDTH(DMG_W), .DEPTH(MAX_ZONES)) u_dmg_ram (
    .clk_i(clk_i), .we_i(we_dmg), .waddr_i(z_wa), .wdata_i(dmg_wd),
    .raddr_i(z_ra), .rdata_o(dmg_rd)
  );
  esz_ram #(.WIDTH(SYS_W), .DEPTH(MAX_ZONES)) u_sys_ram (
    .clk_i(clk_i), .we_i(we_sys), .waddr_i(z_wa), .wdata_i(word_value_i),
    .raddr_i(z_ra), .rdata_o(sys_rd)
  );

  // Query operands held for the whole search.
  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      sys_q <= system_id_i;
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
      pz_q  <= pos_z_i;
    end
  end

  always_comb begin
    case (i_q)
      2'd0:    pos_sel = px_q;
      2'd1:    pos_sel = py_q;
      default: pos_sel = pz_q;
    endcase
  end

  esz_arith u_arith (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .pos_i(pos_sel), .rot_i(rot_rd),
    .off_i(off_rd), .size_i(ax_rd), .stat_o(stat)
  );

  // Sequencer: next state, counters and arithmetic commands.
  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    count_d    = count_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    lethal_d   = lethal_q;
    found_d    = found_q;
    idx_d      = idx_q;
    dmg_d      = dmg_q;
    cand_dmg_d = cand_dmg_q;
    cmd        = '0;
    case (state_q)
      S_IDLE: begin
        if (query_acc) begin
          count_d  = (32'(zones_q) > MAX_ZONES) ? CNT_W'(MAX_ZONES) : CNT_W'(zones_q);
          lethal_d = (mode_i == MODE_LETHAL);
          slot_d   = '0;
          found_d  = 1'b0;
          idx_d    = '0;
          dmg_d    = '0;
          state_d  = (count_d == '0) ? S_OUT : S_HDR_RD;
        end
      end
      S_HDR_RD: state_d = S_HDR_CHK;
      S_HDR_CHK: begin
        cand_dmg_d = dmg_rd;
        cmd.sum_clr = 1'b1;
        i_d = '0;
        j_d = '0;
        if (sys_rd == sys_q && (!lethal_q || dmg_rd > thr_q)) begin
          state_d = S_ROT_RD;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_ROT_RD: state_d = S_ROT_MAC;
      S_ROT_MAC: begin
        cmd.mac_first = (i_q == 2'd0);
        cmd.mac       = (i_q != 2'd0);
        if (i_q == 2'd2) begin
          state_d = S_CHECK;
        end else begin
          i_d     = i_q + 2'd1;
          state_d = S_ROT_RD;
        end
      end
      S_CHECK: begin
        if (stat.axis_fail) begin
          state_d = S_NEXT;
        end else begin
          cmd.div_init = 1'b1;
          k_d     = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        k_d = k_q + STEP_W'(1);
        if (k_q == DIV_LAST) begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        i_d = '0;
        if (j_q == 2'd2) begin
          state_d = S_DECIDE;
        end else begin
          j_d     = j_q + 2'd1;
          state_d = S_ROT_RD;
        end
      end
      S_DECIDE: begin
        if (stat.in_zone) begin
          found_d = 1'b1;
          idx_d   = SLOT_W'(slot_q);
          dmg_d   = cand_dmg_q;
          state_d = S_OUT;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (slot_q + CNT_W'(1) == count_q) begin
          state_d = S_OUT;
        end else begin
          slot_d  = slot_q + CNT_W'(1);
          state_d = S_HDR_RD;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      slot_q   <= '0;
      count_q  <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      lethal_q <= 1'b0;
      found_q  <= 1'b0;
      idx_q    <= '0;
      dmg_q    <= '0;
    end else begin
      state_q  <= state_d;
      slot_q   <= slot_d;
      count_q  <= count_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      lethal_q <= lethal_d;
      found_q  <= found_d;
      idx_q    <= idx_d;
      dmg_q    <= dmg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_dmg_q <= cand_dmg_d;
  end

  assign found_o       = found_q;
  assign zone_index_o  = idx_q;
  assign zone_damage_o = dmg_q;

  // The block never takes a transaction while a result waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while result pending");

  // A miss reports zero index and zero damage.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (zone_index_o == '0 && zone_damage_o == '0))
    else $error("miss result not cleared");

  // A lethal hit carries damage above the threshold.
  a_lethal_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o && lethal_q) |-> (zone_damage_o > thr_q))
    else $error("lethal hit below threshold");

  // A query always leaves the idle state.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_acc |=> !in_ready_o) else $error("query did not start");

endmodule
